// File: rtl/core/gnso_pkg.sv
// Types and constants shared by the greedy nearest segment ordering block.
`timescale 1ns / 1ps
`default_nettype none

package gnso_pkg;

    localparam int COORD_BITS   = 24;
    localparam int IDX_BITS     = 6;
    localparam int ABS_BITS     = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * COORD_BITS + 1;
    localparam int DIST_BITS    = 2 * COORD_BITS + 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_Z = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DIST_BITS-1:0] dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        coord_t head_x;
        coord_t head_y;
        coord_t head_z;
        coord_t tail_x;
        coord_t tail_y;
        coord_t tail_z;
        logic   final_segment;
    } item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] segment_index;
        logic                end_of_order;
        logic                dropped;
    } result_t;

    // candidate tag carried alongside the distance pipeline
    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
    } cand_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/gnso_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gnso_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/gnso_dist.sv
// Two-stage squared distance pipeline: absolute differences, then squares and sum.
`timescale 1ns / 1ps
`default_nettype none

module gnso_dist (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gnso_pkg::point_t          pt_a,
    input  wire gnso_pkg::point_t          pt_b,
    input  wire gnso_pkg::cand_tag_t       tag_in,
    output gnso_pkg::dist_t                dist_sq,
    output gnso_pkg::cand_tag_t            tag_out
);

    localparam int AB = gnso_pkg::ABS_BITS;
    localparam int SB = gnso_pkg::SQ_BITS;
    localparam int DB = gnso_pkg::DIST_BITS;

    logic signed [AB-1:0] dx, dy, dz;
    logic [AB-1:0] ax_reg, ay_reg, az_reg;
    logic [SB-1:0] sx_reg, sy_reg, sz_reg;
    logic [2*AB-1:0] px, py, pz;
    gnso_pkg::cand_tag_t tag2_reg, tag3_reg;

    assign dx = AB'(pt_a.x) - AB'(pt_b.x);
    assign dy = AB'(pt_a.y) - AB'(pt_b.y);
    assign dz = AB'(pt_a.z) - AB'(pt_b.z);

    assign px = ax_reg * ax_reg;
    assign py = ay_reg * ay_reg;
    assign pz = az_reg * az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= dx[AB-1] ? AB'(-dx) : AB'(dx);
        ay_reg <= dy[AB-1] ? AB'(-dy) : AB'(dy);
        az_reg <= dz[AB-1] ? AB'(-dz) : AB'(dz);
        sx_reg <= px[SB-1:0];
        sy_reg <= py[SB-1:0];
        sz_reg <= pz[SB-1:0];
    end

    assign dist_sq = DB'(sx_reg) + DB'(sy_reg) + DB'(sz_reg);
    assign tag_out = tag3_reg;

endmodule

`default_nettype wire

// File: rtl/core/greedy_nearest_segment_order.sv
// Top level: greedy nearest-neighbour ordering of loaded path segments.
//
//   channel   direction  handshake               payload
//   item      in         item_valid/item_stall   gnso_pkg::item_t
//   result    out        result_valid/result_stall gnso_pkg::result_t
//   cfg       in         cfg_we                  cfg_index, cfg_data
//
// Loading accepts one segment per cycle. The final segment starts the ordering;
// each placement streams all n loaded heads through the head RAM read port, then
// drains the distance pipeline, reads the chosen tail and emits the result.
// Reset clears counts, mask and the reference point; RAM contents are not cleared.
// A stalled result holds the sequencer in its emit step; items are refused while ordering.
`timescale 1ns / 1ps
`default_nettype none

module greedy_nearest_segment_order #(
    parameter int MAX_SEGMENTS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire gnso_pkg::item_t                   item,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output gnso_pkg::result_t                      result,
    input  wire logic                              cfg_we,
    input  wire logic [gnso_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [gnso_pkg::COORD_BITS-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int PW     = $bits(gnso_pkg::point_t);
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [2:0] {S_LOAD, S_SCAN, S_DRAIN, S_TAIL, S_EMIT} state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        scan_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [1:0]              drain_reg;
    logic                    overflow_reg;
    logic [MAX_SEGMENTS-1:0] placed_reg;
    logic                    best_found_reg;
    logic [ADDR_W-1:0]       best_idx_reg;
    gnso_pkg::dist_t         best_dist_reg;
    gnso_pkg::point_t        chain_reg;
    gnso_pkg::point_t        ref_reg;
    logic                    result_valid_reg;
    gnso_pkg::result_t       result_reg;
    gnso_pkg::cand_tag_t     tag1_reg;

    logic                item_accept;
    logic                store_we;
    logic [ADDR_W-1:0]   scan_addr;
    gnso_pkg::point_t    head_wdata, tail_wdata;
    logic [PW-1:0]       head_rdata, tail_rdata;
    gnso_pkg::cand_tag_t tag_issue, tag3;
    gnso_pkg::dist_t     dist3;
    logic                scan_last, pos_last, out_free, emit_go;

    assign item_accept = item_valid && (state_reg == S_LOAD);
    assign item_stall  = (state_reg != S_LOAD);
    assign store_we    = item_accept && (count_reg != CNT_W'(MAX_SEGMENTS));
    assign scan_addr   = scan_reg[ADDR_W-1:0];
    assign scan_last   = (scan_reg == count_reg - CNT_W'(1));
    assign pos_last    = (pos_reg == count_reg - CNT_W'(1));
    assign out_free    = !result_valid_reg || !result_stall;
    assign emit_go     = (state_reg == S_EMIT) && out_free;

    assign head_wdata = '{x: item.head_x, y: item.head_y, z: item.head_z};
    assign tail_wdata = '{x: item.tail_x, y: item.tail_y, z: item.tail_z};

    assign tag_issue.valid = (state_reg == S_SCAN) && !placed_reg[scan_addr];
    assign tag_issue.idx   = gnso_pkg::IDX_BITS'(scan_addr);

    gnso_ram #(.WIDTH(PW), .DEPTH(MAX_SEGMENTS)) u_head_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (head_wdata),
        .raddr (scan_addr),
        .rdata (head_rdata)
    );

    gnso_ram #(.WIDTH(PW), .DEPTH(MAX_SEGMENTS)) u_tail_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (tail_wdata),
        .raddr (best_idx_reg),
        .rdata (tail_rdata)
    );

    gnso_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .pt_a    (gnso_pkg::point_t'(head_rdata)),
        .pt_b    (chain_reg),
        .tag_in  (tag1_reg),
        .dist_sq (dist3),
        .tag_out (tag3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gnso_pkg::CFG_REF_X: ref_reg.x <= cfg_data;
                gnso_pkg::CFG_REF_Y: ref_reg.y <= cfg_data;
                gnso_pkg::CFG_REF_Z: ref_reg.z <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            scan_reg         <= '0;
            pos_reg          <= '0;
            drain_reg        <= '0;
            overflow_reg     <= 1'b0;
            placed_reg       <= '0;
            best_found_reg   <= 1'b0;
            best_idx_reg     <= '0;
            best_dist_reg    <= '0;
            chain_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            tag1_reg         <= '0;
        end
        else
        begin
            tag1_reg <= tag_issue;

            if (result_valid_reg && !result_stall && !emit_go)
            begin
                result_valid_reg <= 1'b0;
            end

            // ties keep the earlier, lower index
            if (tag3.valid && (!best_found_reg || dist3 < best_dist_reg))
            begin
                best_found_reg <= 1'b1;
                best_dist_reg  <= dist3;
                best_idx_reg   <= tag3.idx[ADDR_W-1:0];
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (item_accept)
                    begin
                        if (store_we)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (item.final_segment)
                        begin
                            state_reg      <= S_SCAN;
                            scan_reg       <= '0;
                            pos_reg        <= '0;
                            best_found_reg <= 1'b0;
                            placed_reg     <= '0;
                            chain_reg      <= ref_reg;
                        end
                    end
                end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= '0;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == DRAIN_LAST)
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    placed_reg[best_idx_reg] <= 1'b1;
                    state_reg                <= S_EMIT;
                end
                S_EMIT:
                begin
                    chain_reg <= gnso_pkg::point_t'(tail_rdata);
                    if (out_free)
                    begin
                        result_valid_reg         <= 1'b1;
                        result_reg.segment_index <= gnso_pkg::IDX_BITS'(best_idx_reg);
                        result_reg.end_of_order  <= pos_last;
                        result_reg.dropped       <= overflow_reg;
                        if (pos_last)
                        begin
                            state_reg    <= S_LOAD;
                            count_reg    <= '0;
                            overflow_reg <= 1'b0;
                            placed_reg   <= '0;
                        end
                        else
                        begin
                            state_reg      <= S_SCAN;
                            pos_reg        <= pos_reg + CNT_W'(1);
                            scan_reg       <= '0;
                            best_found_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/gnso_checker.sv
// Port-level checks for the segment ordering block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gnso_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_stall,
    input wire gnso_pkg::item_t   item,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire gnso_pkg::result_t result
);

    // a final transfer starts an ordering, which refuses further items
    a_final_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.final_segment |=> item_stall)
        else $error("input not stalled after final segment");

    // an unfinished ordering keeps the input stalled
    a_busy_mid_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_order |-> item_stall)
        else $error("input open while ordering incomplete");

    // nothing is emitted while segments are still being loaded
    a_no_result_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !item_stall && !result_valid |=> !result_valid || item_stall || $past(result_stall))
        else $error("result appeared during loading");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind greedy_nearest_segment_order gnso_checker u_gnso_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// File: tb/greedy_nearest_segment_order_test.sv
// Self-checking testbench for greedy_nearest_segment_order with its own ordering predictor.
`timescale 1ns / 1ps

module greedy_nearest_segment_order_test;

    localparam int SLOTS = 32;
    localparam int DIRECTED_ROWS = 20;
    localparam int I_MAX = 8388607;
    localparam int I_MIN = -8388608;
    localparam gnso_pkg::coord_t C_MAX = 24'sh7fffff;
    localparam gnso_pkg::coord_t C_MIN = 24'sh800000;
    localparam logic [gnso_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam gnso_pkg::result_t LONE =
        '{segment_index: '0, end_of_order: 1'b1, dropped: 1'b0};
    localparam gnso_pkg::result_t NONE_DUE = '0;

    typedef struct {
        int                hx;
        int                hy;
        int                hz;
        int                tx;
        int                ty;
        int                tz;
        bit                fin;
        bit                typed;
        gnso_pkg::result_t want;
    } step_row_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  item_valid = 1'b0;
    logic                                  item_stall;
    gnso_pkg::item_t                       item = '0;
    logic                                  result_valid;
    logic                                  result_stall = 1'b0;
    gnso_pkg::result_t                     result;
    logic                                  cfg_we = 1'b0;
    logic [gnso_pkg::CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [gnso_pkg::COORD_BITS-1:0]       cfg_data = '0;

    int send_idle_pct = 9;
    int recv_idle_pct = 69;
    int mismatches = 0;

    // predictor state
    gnso_pkg::point_t  ref_pt = '0;
    gnso_pkg::point_t  head_pts [SLOTS];
    gnso_pkg::point_t  tail_pts [SLOTS];
    int                held = 0;
    logic              spilled = 1'b0;
    gnso_pkg::result_t pending_order [$];
    gnso_pkg::result_t due;

    step_row_t steps [DIRECTED_ROWS] = '{
        '{0, 0, 0, 0, 0, 0, 1'b1, 1'b1, LONE},
        '{I_MAX, I_MAX, I_MAX, I_MIN, I_MIN, I_MIN, 1'b1, 1'b1, LONE},
        '{I_MIN, I_MIN, I_MIN, I_MAX, I_MAX, I_MAX, 1'b1, 1'b1, LONE},
        '{I_MAX, I_MAX, I_MAX, 0, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{0, 0, 0, I_MAX, I_MAX, I_MAX, 1'b1, 1'b0, NONE_DUE},
        '{100, 0, 0, 100, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{100, 0, 0, 100, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{100, 0, 0, 100, 0, 0, 1'b1, 1'b0, NONE_DUE},
        '{-5, 0, 0, I_MIN, I_MIN, I_MIN, 1'b0, 1'b0, NONE_DUE},
        '{5, 0, 0, 0, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{0, 0, 0, 0, 0, 0, 1'b1, 1'b0, NONE_DUE},
        '{I_MIN, I_MIN, I_MIN, I_MAX, I_MAX, I_MAX, 1'b0, 1'b0, NONE_DUE},
        '{I_MAX, I_MAX, I_MAX, I_MIN, I_MIN, I_MIN, 1'b0, 1'b0, NONE_DUE},
        '{I_MIN, I_MAX, I_MIN, 0, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{I_MAX, I_MIN, I_MAX, I_MIN, I_MAX, I_MIN, 1'b1, 1'b0, NONE_DUE},
        '{0, 0, I_MIN, 0, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{I_MAX, 0, 0, 0, 0, 0, 1'b0, 1'b0, NONE_DUE},
        '{0, -8388607, 0, 0, 0, 0, 1'b1, 1'b0, NONE_DUE},
        '{1, -1, 1, -1, 1, -1, 1'b1, 1'b1, LONE},
        '{-1, -1, -1, -1, -1, -1, 1'b1, 1'b1, LONE}
    };

    greedy_nearest_segment_order #(
        .MAX_SEGMENTS(SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic gnso_pkg::item_t row_item(input step_row_t row);
        gnso_pkg::item_t seg;
        seg.head_x        = gnso_pkg::coord_t'(row.hx);
        seg.head_y        = gnso_pkg::coord_t'(row.hy);
        seg.head_z        = gnso_pkg::coord_t'(row.hz);
        seg.tail_x        = gnso_pkg::coord_t'(row.tx);
        seg.tail_y        = gnso_pkg::coord_t'(row.ty);
        seg.tail_z        = gnso_pkg::coord_t'(row.tz);
        seg.final_segment = row.fin;
        row_item = seg;
    endfunction

    function automatic void queue_due(input gnso_pkg::result_t r);
        pending_order = {pending_order, r};
    endfunction

    function automatic gnso_pkg::dist_t span_sq(input gnso_pkg::point_t a,
                                                input gnso_pkg::point_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        span_sq = gnso_pkg::dist_t'(dx * dx + dy * dy + dz * dz);
    endfunction

    // load one segment; a final one produces the greedy chain from the reference point
    function automatic void absorb_segment(input gnso_pkg::item_t seg, input bit keep);
        gnso_pkg::point_t  from;
        bit                placed [SLOTS];
        gnso_pkg::dist_t   best;
        gnso_pkg::dist_t   span;
        int                pick;
        int                n;
        int                pos;
        int                i;
        bit                found;
        bit                taken;
        gnso_pkg::result_t r;
        if (held < SLOTS) begin
            head_pts[held] = {seg.head_x, seg.head_y, seg.head_z};
            tail_pts[held] = {seg.tail_x, seg.tail_y, seg.tail_z};
            held++;
        end
        else begin
            spilled = 1'b1;
        end
        if (seg.final_segment) begin
            n = held;
            placed = '{default: 1'b0};
            from = ref_pt;
            for (pos = 0; pos < n; pos++) begin
                pick = 0;
                found = 1'b0;
                taken = 1'b0;
                best = '0;
                for (i = 0; i < n; i++) begin
                    if (!placed[i] && !taken) begin
                        if (pos == n - 1) begin
                            pick = i;
                            taken = 1'b1;
                        end
                        else begin
                            span = span_sq(head_pts[i], from);
                            if (!found || span < best) begin
                                found = 1'b1;
                                best = span;
                                pick = i;
                            end
                        end
                    end
                end
                placed[pick] = 1'b1;
                from = tail_pts[pick];
                r.segment_index = gnso_pkg::IDX_BITS'(pick);
                r.end_of_order = (pos == n - 1);
                r.dropped = spilled;
                if (keep)
                    queue_due(r);
            end
            held = 0;
            spilled = 1'b0;
        end
    endfunction

    function automatic gnso_pkg::coord_t pick_coord(input int style,
                                                    input gnso_pkg::coord_t centre);
        case (style)
            0: pick_coord = gnso_pkg::coord_t'($urandom);
            1: pick_coord = centre + gnso_pkg::coord_t'($urandom_range(6))
                            - gnso_pkg::coord_t'(3);
            default: begin
                case ($urandom_range(4))
                    0: pick_coord = C_MIN;
                    1: pick_coord = C_MAX;
                    2: pick_coord = '0;
                    3: pick_coord = '1;
                    default: pick_coord = gnso_pkg::coord_t'(1);
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: order mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // holds valid high from one transfer to the next unless the sender idles
    task automatic send_segment(input gnso_pkg::item_t seg, input bit keep);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= seg;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_segment(seg, keep);
    endtask

    task automatic send_path(input int len, input int style);
        gnso_pkg::point_t pool [3];
        gnso_pkg::item_t  seg;
        int               k;
        for (k = 0; k < 3; k++)
            pool[k] = {pick_coord($urandom_range(2), ref_pt.x),
                       pick_coord($urandom_range(2), ref_pt.y),
                       pick_coord($urandom_range(2), ref_pt.z)};
        for (k = 0; k < len; k++) begin
            if (style == 3) begin
                {seg.head_x, seg.head_y, seg.head_z} = pool[$urandom_range(2)];
                {seg.tail_x, seg.tail_y, seg.tail_z} = pool[$urandom_range(2)];
            end
            else begin
                seg.head_x = pick_coord(style, ref_pt.x);
                seg.head_y = pick_coord(style, ref_pt.y);
                seg.head_z = pick_coord(style, ref_pt.z);
                seg.tail_x = pick_coord(style, ref_pt.x);
                seg.tail_y = pick_coord(style, ref_pt.y);
                seg.tail_z = pick_coord(style, ref_pt.z);
            end
            seg.final_segment = (k == len - 1);
            send_segment(seg, 1'b1);
        end
    endtask

    task automatic random_paths(input int target);
        int sent;
        int len;
        int r;
        int style;
        sent = 0;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(6, 1);
            else if (r < 93)
                len = $urandom_range(20, 7);
            else if (r < 97)
                len = SLOTS;
            else
                len = $urandom_range(SLOTS + 4, SLOTS + 1);
            r = $urandom_range(99);
            style = (r < 40) ? 0 : (r < 65) ? 1 : (r < 80) ? 2 : 3;
            send_path(len, style);
            sent += len;
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pending_order.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gnso_pkg::CFG_IDX_BITS-1:0] idx,
                             input gnso_pkg::coord_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            gnso_pkg::CFG_REF_X: ref_pt.x = val;
            gnso_pkg::CFG_REF_Y: ref_pt.y = val;
            gnso_pkg::CFG_REF_Z: ref_pt.z = val;
            default: ;
        endcase
    endtask

    task automatic write_ref(input gnso_pkg::coord_t x, input gnso_pkg::coord_t y,
                             input gnso_pkg::coord_t z);
        write_reg(gnso_pkg::CFG_REF_X, x);
        write_reg(gnso_pkg::CFG_REF_Y, y);
        write_reg(gnso_pkg::CFG_REF_Z, z);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && result_valid && !result_stall) begin
            if (pending_order.size() == 0) begin
                report_mismatch("unexpected transfer, segment_index", -1,
                                int'(result.segment_index));
            end
            else begin
                due = pending_order.pop_front();
                if (result.segment_index != due.segment_index)
                    report_mismatch("segment_index", int'(due.segment_index),
                                    int'(result.segment_index));
                if (result.end_of_order != due.end_of_order)
                    report_mismatch("end_of_order", int'(due.end_of_order),
                                    int'(result.end_of_order));
                if (result.dropped != due.dropped)
                    report_mismatch("dropped", int'(due.dropped), int'(result.dropped));
            end
        end
    end

    initial begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reference point still at its reset value here
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            send_segment(row_item(steps[k]), !steps[k].typed);
            if (steps[k].typed)
                queue_due(steps[k].want);
        end
        settle();

        // unlisted index must leave the reference point alone; full store then overflow
        write_reg(CFG_UNUSED, C_MIN);
        cfg_we <= 1'b0;
        send_path(SLOTS + 2, 1);
        settle();

        write_ref(gnso_pkg::coord_t'($urandom), gnso_pkg::coord_t'($urandom),
                  gnso_pkg::coord_t'($urandom));
        random_paths(140);
        settle();

        send_idle_pct = 69;
        recv_idle_pct = 9;
        write_ref(C_MAX, C_MIN, C_MAX);
        random_paths(140);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_ref(C_MIN, C_MAX, C_MIN);
        random_paths(60);
        settle();

        write_ref(gnso_pkg::coord_t'($urandom_range(2000)) - gnso_pkg::coord_t'(1000), '0,
                  gnso_pkg::coord_t'($urandom));
        random_paths(60);
        settle();

        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
